[sv/lrre_pkg.sv]
// ----------------------------------------------------------------------------
// lrre_pkg
// Shared types and constants for the labelled region row extents unit.
// ----------------------------------------------------------------------------
package lrre_pkg;

  localparam int GRID_ROWS  = 64;
  localparam int GRID_COLS  = 64;
  localparam int NUM_LABELS = 16;

  localparam int ROW_W   = 6;
  localparam int COL_W   = 6;
  localparam int LABEL_W = 4;
  localparam int ACT_W   = 2;

  localparam int LABEL_AW   = $clog2(NUM_LABELS);
  localparam int SPAN_DEPTH = NUM_LABELS * GRID_ROWS;
  localparam int SPAN_AW    = $clog2(SPAN_DEPTH);

  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ELEM  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [LABEL_W-1:0] label;
  } in_item_t;

  typedef struct packed {
    logic             cell_present;
    logic [ROW_W-1:0] first_row;
    logic [ROW_W-1:0] last_row;
    logic             row_present;
    logic [COL_W-1:0] low_col;
    logic [COL_W-1:0] high_col;
  } out_item_t;

  typedef struct packed {
    logic             seen;
    logic [COL_W-1:0] low_col;
    logic [COL_W-1:0] high_col;
  } span_ent_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_EL_READ,
    ST_EL_WRITE,
    ST_Q_READ,
    ST_Q_RESP
  } state_t;

  typedef struct packed {
    logic latch;
    logic clr_labels;
    logic sweep_wr;
    logic mem_rd;
    logic elem_wr;
    logic resp;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_last;
  } dp_stat_t;

endpackage

[sv/lrre_ctrl.sv]
// ----------------------------------------------------------------------------
// lrre_ctrl
// Sequencer: decodes accepted beats and steps the datapath through read,
// update, response and presence clearing sweeps.
// ----------------------------------------------------------------------------
module lrre_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lrre_pkg::ACT_W-1:0] action,
  input  lrre_pkg::dp_stat_t         stat,
  output lrre_pkg::dp_cmd_t          cmd,
  output logic                       busy
);
  import lrre_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (action)
            ACT_CLEAR: state_nxt = ST_CLEAR;
            ACT_ELEM:  state_nxt = ST_EL_READ;
            ACT_QUERY: state_nxt = ST_Q_READ;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR:    if (stat.sweep_last) state_nxt = ST_IDLE;
      ST_EL_READ:  state_nxt = ST_EL_WRITE;
      ST_EL_WRITE: state_nxt = ST_IDLE;
      ST_Q_READ:   state_nxt = ST_Q_RESP;
      ST_Q_RESP:   state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy           = 1'b0;
        cmd.latch      = start;
        cmd.clr_labels = start && (action == ACT_CLEAR);
      end
      ST_CLEAR:    cmd.sweep_wr = 1'b1;
      ST_EL_READ:  cmd.mem_rd   = 1'b1;
      ST_EL_WRITE: cmd.elem_wr  = 1'b1;
      ST_Q_READ:   cmd.mem_rd   = 1'b1;
      ST_Q_RESP:   cmd.resp     = 1'b1;
      default:     busy         = 1'b1;
    endcase
  end

endmodule

[sv/lrre_datapath.sv]
// ----------------------------------------------------------------------------
// lrre_datapath
// Per-label row extent registers, span memory holding column extents per
// label and row, clearing sweep counter and result register.
// ----------------------------------------------------------------------------
module lrre_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  lrre_pkg::in_item_t  in_data,
  input  lrre_pkg::dp_cmd_t   cmd,
  output lrre_pkg::dp_stat_t  stat,
  output lrre_pkg::out_item_t out_data,
  output logic                out_strobe
);
  import lrre_pkg::*;

  logic [ROW_W-1:0]   row_r;
  logic [COL_W-1:0]   col_r;
  logic [LABEL_W-1:0] label_r;
  logic               label_ok_r;
  logic               row_ok_r;
  logic               col_ok_r;

  logic [NUM_LABELS-1:0] label_seen_r;
  logic [ROW_W-1:0]      label_first_r [NUM_LABELS];
  logic [ROW_W-1:0]      label_last_r  [NUM_LABELS];

  span_ent_t         span_mem [SPAN_DEPTH];
  span_ent_t         rd_q_r;
  logic [SPAN_AW-1:0] sweep_addr_r;

  logic [SPAN_AW-1:0]  span_idx;
  logic [LABEL_AW-1:0] lab_idx;
  logic                elem_ok;
  logic                mem_we;
  logic [SPAN_AW-1:0]  mem_waddr;
  span_ent_t           mem_wdata;
  span_ent_t           upd_ent;
  out_item_t           resp_item;
  out_item_t           out_data_r;
  logic                out_strobe_r;

  assign lab_idx  = label_r[LABEL_AW-1:0];
  assign span_idx = SPAN_AW'(lab_idx) * SPAN_AW'(GRID_ROWS) + SPAN_AW'(row_r);
  assign elem_ok  = label_ok_r && row_ok_r && col_ok_r;
  assign stat.sweep_last = (sweep_addr_r == SPAN_AW'(SPAN_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      row_r      <= in_data.row;
      col_r      <= in_data.col;
      label_r    <= in_data.label;
      label_ok_r <= int'(in_data.label) < NUM_LABELS;
      row_ok_r   <= int'(in_data.row) < GRID_ROWS;
      col_ok_r   <= int'(in_data.col) < GRID_COLS;
    end
  end

  // sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_addr_r <= '0;
    end else if (cmd.sweep_wr) begin
      sweep_addr_r <= stat.sweep_last ? '0 : sweep_addr_r + 1'b1;
    end
  end

  // label presence and row extents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      label_seen_r <= '0;
    end else if (cmd.clr_labels) begin
      label_seen_r <= '0;
    end else if (cmd.elem_wr && elem_ok) begin
      label_seen_r[lab_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.elem_wr && elem_ok) begin
      if (!label_seen_r[lab_idx]) begin
        label_first_r[lab_idx] <= row_r;
        label_last_r[lab_idx]  <= row_r;
      end else begin
        if (row_r < label_first_r[lab_idx]) label_first_r[lab_idx] <= row_r;
        if (row_r > label_last_r[lab_idx])  label_last_r[lab_idx]  <= row_r;
      end
    end
  end

  // span update from the entry read in the previous cycle
  always_comb begin
    upd_ent.seen = 1'b1;
    if (!rd_q_r.seen) begin
      upd_ent.low_col  = col_r;
      upd_ent.high_col = col_r;
    end else begin
      upd_ent.low_col  = (col_r < rd_q_r.low_col)  ? col_r : rd_q_r.low_col;
      upd_ent.high_col = (col_r > rd_q_r.high_col) ? col_r : rd_q_r.high_col;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = span_idx;
    mem_wdata = upd_ent;
    priority if (cmd.sweep_wr) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_addr_r;
      mem_wdata = '0;
    end else if (cmd.elem_wr) begin
      mem_we = elem_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      span_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rd_q_r <= span_mem[span_idx];
    end
  end

  // query result
  always_comb begin
    resp_item = '0;
    if (label_ok_r && label_seen_r[lab_idx]) begin
      resp_item.cell_present = 1'b1;
      resp_item.first_row    = label_first_r[lab_idx];
      resp_item.last_row     = label_last_r[lab_idx];
      if (row_ok_r && rd_q_r.seen) begin
        resp_item.row_present = 1'b1;
        resp_item.low_col     = rd_q_r.low_col;
        resp_item.high_col    = rd_q_r.high_col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.resp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp) begin
      out_data_r <= resp_item;
    end
  end

  assign out_data   = out_data_r;
  assign out_strobe = out_strobe_r;

endmodule

[sv/labeled_region_row_extents_unit.sv]
// ----------------------------------------------------------------------------
// labeled_region_row_extents_unit
// Tracks first/last row per label and low/high column per label and row from
// a row-major label grid stream; answers extent queries.
//
//   channel  ports                     direction  handshake
//   input    start, busy, in_data      in         start && !busy
//   result   out_strobe, out_data      out        one-cycle strobe
//
// A grid element steps through accept, span memory read and write back, and a
// query through accept, span memory read and response; the result and its
// strobe are registered from the response state.
// A clear empties label presence at once, then sweeps the span memory one
// entry a cycle, all SPAN_DEPTH (1024) entries, with busy high.
// After reset the same sweep runs before the first beat is taken.
// The receiver cannot stall; each result stays on out_data until the next one.
// ----------------------------------------------------------------------------
module labeled_region_row_extents_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lrre_pkg::in_item_t  in_data,
  output logic                out_strobe,
  output lrre_pkg::out_item_t out_data
);
  import lrre_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lrre_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_data.action),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  lrre_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .cmd        (cmd),
    .stat       (stat),
    .out_data   (out_data),
    .out_strobe (out_strobe)
  );

endmodule

[bench/lrre_extent_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lrre_extent_checker
// Watches the command and result channels of the row extents unit, keeps its
// own copy of the label extents and row spans, and compares every result
// strobe with the oldest predicted query answer.
// ----------------------------------------------------------------------------
module lrre_extent_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  lrre_pkg::in_item_t  in_data,
  input  logic                out_strobe,
  input  lrre_pkg::out_item_t out_data,
  output int                  err_count,
  output int                  results_seen,
  output int                  results_owed
);
  import lrre_pkg::*;

  bit               region_seen   [NUM_LABELS];
  logic [ROW_W-1:0] region_top    [NUM_LABELS];
  logic [ROW_W-1:0] region_bottom [NUM_LABELS];
  bit               row_span_seen [SPAN_DEPTH];
  logic [COL_W-1:0] row_span_lo   [SPAN_DEPTH];
  logic [COL_W-1:0] row_span_hi   [SPAN_DEPTH];

  out_item_t extent_q[$];

  function automatic void apply_beat(input in_item_t it);
    int lab;
    int r;
    int c;
    int idx;
    out_item_t ans;
    lab = it.label;
    r   = it.row;
    c   = it.col;
    idx = lab * GRID_ROWS + r;
    ans = '0;
    case (it.action)
      ACT_CLEAR: begin
        foreach (region_seen[i]) region_seen[i] = 1'b0;
        foreach (row_span_seen[i]) row_span_seen[i] = 1'b0;
      end
      ACT_ELEM: begin
        if (r < GRID_ROWS && c < GRID_COLS && lab < NUM_LABELS) begin
          if (!region_seen[lab]) begin
            region_seen[lab]   = 1'b1;
            region_top[lab]    = it.row;
            region_bottom[lab] = it.row;
          end else begin
            if (it.row < region_top[lab]) region_top[lab] = it.row;
            if (it.row > region_bottom[lab]) region_bottom[lab] = it.row;
          end
          if (!row_span_seen[idx]) begin
            row_span_seen[idx] = 1'b1;
            row_span_lo[idx]   = it.col;
            row_span_hi[idx]   = it.col;
          end else begin
            if (it.col < row_span_lo[idx]) row_span_lo[idx] = it.col;
            if (it.col > row_span_hi[idx]) row_span_hi[idx] = it.col;
          end
        end
      end
      ACT_QUERY: begin
        if (lab < NUM_LABELS && region_seen[lab]) begin
          ans.cell_present = 1'b1;
          ans.first_row    = region_top[lab];
          ans.last_row     = region_bottom[lab];
          if (r < GRID_ROWS && row_span_seen[idx]) begin
            ans.row_present = 1'b1;
            ans.low_col     = row_span_lo[idx];
            ans.high_col    = row_span_hi[idx];
          end
        end
        extent_q.insert(extent_q.size(), ans);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic int field_differs(input string fname, input logic [5:0] want,
                                       input logic [5:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, fname, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    int bad;
    if (rst_n) begin
      if (out_strobe) begin
        if (extent_q.size() == 0) begin
          $display("%0t: result with none expected, expected none, got %p", $time, out_data);
          err_count++;
        end else begin
          want = extent_q.pop_front();
          bad  = 0;
          bad += field_differs("cell_present", 6'(want.cell_present), 6'(out_data.cell_present));
          bad += field_differs("first_row", want.first_row, out_data.first_row);
          bad += field_differs("last_row", want.last_row, out_data.last_row);
          bad += field_differs("row_present", 6'(want.row_present), 6'(out_data.row_present));
          bad += field_differs("low_col", want.low_col, out_data.low_col);
          bad += field_differs("high_col", want.high_col, out_data.high_col);
          if (bad != 0) err_count++;
          results_seen++;
        end
      end
      if (start && !busy) apply_beat(in_data);
    end
    results_owed <= extent_q.size();
  end

endmodule

[bench/tb_labeled_region_row_extents_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_labeled_region_row_extents_unit
// Drives directed and random clear, grid element, query and unused-code beats
// into the row extents unit with random idle bursts; the checker beside the
// unit predicts every query answer and counts mismatches for the verdict.
// ----------------------------------------------------------------------------
module tb_labeled_region_row_extents_unit;
  import lrre_pkg::*;

  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
  localparam int TARGET_BEATS = 1550;
  localparam int TAIL_BEATS   = 150;
  localparam int CYCLE_LIMIT  = 400000;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_data = '0;
  logic      busy;
  logic      out_strobe;
  out_item_t out_data;

  int err_count;
  int results_seen;
  int results_owed;
  int cycle_cnt;
  int beats_sent;
  int n_elem;
  int n_query;
  int n_clear;
  int n_spare;
  int idle_pct;

  labeled_region_row_extents_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  lrre_extent_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_strobe  (out_strobe),
    .out_data    (out_data),
    .err_count   (err_count),
    .results_seen(results_seen),
    .results_owed(results_owed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles", cycle_cnt);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_beat(input logic [ACT_W-1:0] act, input int r, input int c,
                           input int lab);
    in_item_t it;
    it.action = act;
    it.row    = r[ROW_W-1:0];
    it.col    = c[COL_W-1:0];
    it.label  = lab[LABEL_W-1:0];
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    beats_sent++;
    case (act)
      ACT_CLEAR: n_clear++;
      ACT_ELEM:  n_elem++;
      ACT_QUERY: n_query++;
      default:   n_spare++;
    endcase
    if (beats_sent < TARGET_BEATS - TAIL_BEATS && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(14, 1)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (results_owed != 0 || busy);
  endtask

  function automatic int pick_coord();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 63;
      default: return $urandom_range(63);
    endcase
  endfunction

  // row-major sweep over a small rectangle holding a few labels, then queries
  task automatic raster_patch();
    int r0;
    int c0;
    int h;
    int w;
    int qr;
    int labs[3];
    r0 = pick_coord();
    c0 = pick_coord();
    h  = $urandom_range(4, 1);
    w  = $urandom_range(6, 1);
    foreach (labs[i]) labs[i] = $urandom_range(15);
    for (int r = r0; r < r0 + h && r < GRID_ROWS; r++) begin
      for (int c = c0; c < c0 + w && c < GRID_COLS; c++) begin
        if ($urandom_range(9) < 8) send_beat(ACT_ELEM, r, c, labs[$urandom_range(2)]);
      end
    end
    repeat ($urandom_range(4, 1)) begin
      qr = r0 + $urandom_range(h + 1) - 1;
      if (qr < 0) qr = 0;
      if (qr > 63) qr = 63;
      send_beat(ACT_QUERY, qr, $urandom_range(63), labs[$urandom_range(2)]);
    end
  endtask

  initial begin
    int roll;
    bit mid_drained;
    mid_drained = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 30;
    send_beat(ACT_QUERY, 0, 0, 0);
    send_beat(ACT_ELEM, 0, 63, 15);
    send_beat(ACT_ELEM, 0, 0, 15);
    send_beat(ACT_ELEM, 63, 63, 15);
    send_beat(ACT_QUERY, 0, 63, 15);
    send_beat(ACT_QUERY, 5, 0, 15);
    send_beat(ACT_QUERY, 63, 0, 15);
    send_beat(ACT_ELEM, 63, 0, 0);
    send_beat(ACT_ELEM, 0, 63, 0);
    send_beat(ACT_ELEM, 63, 31, 0);
    send_beat(ACT_QUERY, 63, 63, 0);
    send_beat(ACT_QUERY, 0, 0, 0);
    send_beat(ACT_SPARE, 63, 63, 15);
    send_beat(ACT_QUERY, 63, 0, 15);
    send_beat(ACT_CLEAR, 63, 63, 15);
    send_beat(ACT_QUERY, 0, 0, 15);
    send_beat(ACT_ELEM, 10, 20, 15);
    send_beat(ACT_QUERY, 0, 0, 15);
    send_beat(ACT_QUERY, 10, 0, 15);
    send_beat(ACT_QUERY, 63, 0, 0);
    send_beat(ACT_ELEM, 42, 21, 10);
    send_beat(ACT_QUERY, 42, 42, 10);
    wait_drained();

    while (beats_sent < TARGET_BEATS) begin
      if ($urandom_range(7) == 0)
        idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(60, 10);
      roll = $urandom_range(99);
      if (roll < 3) begin
        send_beat(ACT_CLEAR, $urandom_range(63), $urandom_range(63), $urandom_range(15));
      end else if (roll < 60) begin
        raster_patch();
      end else if (roll < 64) begin
        send_beat(ACT_SPARE, $urandom_range(63), $urandom_range(63), $urandom_range(15));
      end else if (roll < 82) begin
        send_beat(ACT_QUERY, pick_coord(), $urandom_range(63), $urandom_range(15));
      end else begin
        send_beat(ACT_ELEM, pick_coord(), pick_coord(), $urandom_range(15));
      end
      if (!mid_drained && beats_sent > TARGET_BEATS / 2) begin
        mid_drained = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (16) @(posedge clk);
    $display("covered %0d grid elements, %0d queries, %0d clears, %0d unused codes",
             n_elem, n_query, n_clear, n_spare);
    $display("%0d query answers compared in %0d cycles", results_seen, cycle_cnt);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
